>>> hw/rtl/checked_vector_alu_macros.svh
// Assertion macros for the RTL datapath
`ifndef CHECKED_VECTOR_ALU_MACROS_SVH
`define CHECKED_VECTOR_ALU_MACROS_SVH

// Check a property on every clock edge outside reset
`define CVA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define CVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cva_pkg.sv
package cva_pkg;

	typedef enum logic [2:0] {
		MODE_LOAD = 3'd0,
		MODE_ADD  = 3'd1,
		MODE_SUB  = 3'd2,
		MODE_MUL  = 3'd3,
		MODE_DIV  = 3'd4,
		MODE_NEG  = 3'd5,
		MODE_DOT  = 3'd6,
		MODE_NOP  = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIV_ZERO = 3'd3,
		ST_DOT_OVF  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DOT,
		S_FINISH,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;     // latch operands and mode
		logic mul_step;  // one partial product step
		logic div_step;  // one quotient bit step
		logic dot_sum;   // form dot sum
		logic finish;    // commit result to lanes and output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mul_done;
		logic div_done;
	} stat_t;

endpackage

>>> hw/rtl/cva_ctrl.sv
module cva_ctrl
	import cva_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  mode_t in_mode,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_NOP;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) mode_q <= in_mode;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					case (in_mode)
						MODE_MUL, MODE_DOT: state_d = S_MUL;
						MODE_DIV: state_d = S_DIV;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_done) state_d = (mode_q == MODE_DOT) ? S_DOT : S_FINISH;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = S_FINISH;
			end
			S_DOT: begin
				cmd.dot_sum = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/cva_datapath.sv
module cva_datapath
	import cva_pkg::*;
#(
	parameter int LANE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [2:0]  in_mode,
	input  logic [63:0] in_x,
	input  logic [63:0] in_y,
	input  logic        in_keep_x,
	input  logic        in_keep_y,
	output logic [2:0]  res_status,
	output logic [63:0] res_x,
	output logic [63:0] res_y,
	output logic [63:0] res_dot
);

	localparam int W = LANE_WIDTH;
	localparam int HW = (W + 1) / 2;
	localparam int CW = $clog2(W + 1);
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	`include "checked_vector_alu_macros.svh"

	logic signed [W-1:0] lane_x_q, lane_y_q;
	logic [W-1:0] bx_q, by_q;
	mode_t mode_q;
	logic keep_x_q, keep_y_q;

	// magnitude-domain work registers, one per lane
	logic [W-1:0] ma_q [2];
	logic [W-1:0] mb_q [2];
	logic [2*W-1:0] acc_q [2];
	logic [W:0] rem_q [2];
	logic [W-1:0] quo_q [2];
	logic [CW-1:0] cnt_q;
	logic [1:0] step_q;
	logic [W+1:0] dsum_q;
	logic dok_q;

	logic [2:0] st_q;
	logic [63:0] ox_q, oy_q, od_q;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [W-1:0] opa [2];
	logic [W-1:0] opb [2];
	assign opa[0] = lane_x_q;
	assign opa[1] = lane_y_q;
	assign opb[0] = bx_q;
	assign opb[1] = by_q;

	// signed products from magnitude products, with range test
	logic neg [2];
	logic pok [2];
	logic [W-1:0] prod [2];
	logic [W:0] tru [2];
	logic [W-1:0] quot [2];
	logic [W-1:0] hi_part [2];
	logic [W-1:0] lo_part [2];
	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign neg[l] = opa[l][W-1] ^ opb[l][W-1];
		assign hi_part[l] = acc_q[l][2*W-1:W];
		assign lo_part[l] = acc_q[l][W-1:0];
		assign pok[l] = (hi_part[l] == '0) &&
			(neg[l] ? (lo_part[l] <= MINV) : (lo_part[l] < MINV));
		assign prod[l] = neg[l] ? (~lo_part[l] + 1'b1) : lo_part[l];
		assign tru[l] = {rem_q[l][W-1:0], quo_q[l][W-1]} - {1'b0, mb_q[l]};
		assign quot[l] = neg[l] ? (~quo_q[l] + 1'b1) : quo_q[l];
	end

	// add/sub/negate/divide checks on lanes
	logic signed [W:0] sx, sy, dx, dy;
	logic aok, sok, nok, dvok;
	always_comb begin
		sx = {lane_x_q[W-1], lane_x_q} + {bx_q[W-1], bx_q};
		sy = {lane_y_q[W-1], lane_y_q} + {by_q[W-1], by_q};
		dx = {lane_x_q[W-1], lane_x_q} - {bx_q[W-1], bx_q};
		dy = {lane_y_q[W-1], lane_y_q} - {by_q[W-1], by_q};
		aok = (sx[W] == sx[W-1]) && (sy[W] == sy[W-1]);
		sok = (dx[W] == dx[W-1]) && (dy[W] == dy[W-1]);
		nok = (lane_x_q != MINV) && (lane_y_q != MINV);
		dvok = (bx_q != '0) && (by_q != '0) &&
			!((lane_x_q == MINV) && (bx_q == '1)) &&
			!((lane_y_q == MINV) && (by_q == '1));
	end

	// one half-by-half partial product per step: step bit 0 picks the
	// operand half, step bit 1 the multiplier half
	logic [HW-1:0] ah [2];
	logic [HW-1:0] bh [2];
	logic [2*HW-1:0] pp [2];
	logic [2*W-1:0] pp_sh [2];
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			ah[l] = step_q[0] ? HW'(ma_q[l] >> HW) : ma_q[l][HW-1:0];
			bh[l] = step_q[1] ? HW'(mb_q[l] >> HW) : mb_q[l][HW-1:0];
			pp[l] = ah[l] * bh[l];
			pp_sh[l] = (2*W)'(pp[l]);
			if (step_q[0]) pp_sh[l] = pp_sh[l] << HW;
			if (step_q[1]) pp_sh[l] = pp_sh[l] << HW;
		end
	end

	assign stat.mul_done = (step_q == 2'd3);
	assign stat.div_done = (cnt_q == CW'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_x_q <= '0;
			lane_y_q <= '0;
			st_q <= ST_OK;
			step_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.start) begin
				mode_q <= mode_t'(in_mode);
				bx_q <= in_x[W-1:0];
				by_q <= in_y[W-1:0];
				keep_x_q <= in_keep_x;
				keep_y_q <= in_keep_y;
				for (int l = 0; l < 2; l++) begin
					ma_q[l] <= mag(l == 0 ? lane_x_q : lane_y_q);
					mb_q[l] <= mag(l == 0 ? in_x[W-1:0] : in_y[W-1:0]);
					acc_q[l] <= '0;
					rem_q[l] <= '0;
					quo_q[l] <= mag(l == 0 ? lane_x_q : lane_y_q);
				end
				step_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.mul_step) begin
				for (int l = 0; l < 2; l++)
					acc_q[l] <= acc_q[l] + pp_sh[l];
				step_q <= step_q + 2'd1;
			end
			if (cmd.div_step) begin
				// restoring divide, one quotient bit per cycle
				for (int l = 0; l < 2; l++) begin
					if (!tru[l][W]) begin
						rem_q[l] <= tru[l];
						quo_q[l] <= {quo_q[l][W-2:0], 1'b1};
					end else begin
						rem_q[l] <= {rem_q[l][W-1:0], quo_q[l][W-1]};
						quo_q[l] <= {quo_q[l][W-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.dot_sum) begin
				dsum_q <= {{2{prod[0][W-1]}}, prod[0]} + {{2{prod[1][W-1]}}, prod[1]};
				dok_q <= pok[0] && pok[1];
			end
			if (cmd.finish) begin
				case (mode_q)
					MODE_LOAD: begin
						if (!keep_x_q) lane_x_q <= bx_q;
						if (!keep_y_q) lane_y_q <= by_q;
						st_q <= ST_OK;
						od_q <= '0;
						ox_q <= 64'(signed'(keep_x_q ? lane_x_q : bx_q));
						oy_q <= 64'(signed'(keep_y_q ? lane_y_q : by_q));
					end
					MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_NEG: begin
						logic ok;
						logic [W-1:0] rx, ry;
						logic [2:0] es;
						ok = 1'b0; rx = '0; ry = '0; es = ST_OVERFLOW;
						case (mode_q)
							MODE_ADD: begin ok = aok; rx = sx[W-1:0]; ry = sy[W-1:0]; end
							MODE_SUB: begin
								ok = sok; rx = dx[W-1:0]; ry = dy[W-1:0]; es = ST_UNDERFLOW;
							end
							MODE_MUL: begin ok = pok[0] && pok[1]; rx = prod[0]; ry = prod[1]; end
							MODE_DIV: begin ok = dvok; rx = quot[0]; ry = quot[1]; es = ST_DIV_ZERO; end
							default: begin
								ok = nok; rx = -lane_x_q; ry = -lane_y_q; es = ST_UNDERFLOW;
							end
						endcase
						st_q <= ok ? ST_OK : es;
						if (ok) begin
							lane_x_q <= rx;
							lane_y_q <= ry;
						end
						ox_q <= 64'(signed'(ok ? rx : lane_x_q));
						oy_q <= 64'(signed'(ok ? ry : lane_y_q));
						od_q <= '0;
					end
					MODE_DOT: begin
						logic dgood;
						dgood = dok_q && (dsum_q[W+1] == dsum_q[W-1]) &&
							(dsum_q[W] == dsum_q[W-1]);
						st_q <= dgood ? ST_OK : ST_DOT_OVF;
						od_q <= dgood ? 64'(signed'(dsum_q[W-1:0])) : '0;
						ox_q <= 64'(signed'(lane_x_q));
						oy_q <= 64'(signed'(lane_y_q));
					end
					default: begin
						st_q <= ST_OK;
						od_q <= '0;
						ox_q <= 64'(signed'(lane_x_q));
						oy_q <= 64'(signed'(lane_y_q));
					end
				endcase
			end
		end
	end

	assign res_status = st_q;
	assign res_x = ox_q;
	assign res_y = oy_q;
	assign res_dot = od_q;

	`CVA_ASSERT(a_one_cmd, $onehot0({cmd.start, cmd.mul_step, cmd.div_step, cmd.dot_sum, cmd.finish}), "datapath got two commands at once")
	`CVA_ASSERT(a_div_count, cmd.div_step |-> cnt_q < CW'(W), "divide ran past the last bit")
	`CVA_ASSERT_NEXT(a_mul_steps, cmd.mul_step && stat.mul_done, !cmd.mul_step, "multiply ran past four steps")

endmodule

>>> hw/rtl/checked_vector_alu.sv
// Sequence: load/add/sub/negate/nop go from accept to finish to output; multiply adds
// partial-product steps, dot a sum step after them, divide one quotient bit per cycle from the per-lane dividers.
// One transaction at a time; the next is accepted after the result is taken.
// The divide loop sets the worst case.
// Reset (arst_n low, asynchronous): both lanes cleared, status success, idle.
module checked_vector_alu
	import cva_pkg::*;
#(
	parameter int LANE_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // mode[2:0], operand_x[66:3], operand_y[130:67], keep_x[131], keep_y[132]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata   // status[2:0], vector_x[66:3], vector_y[130:67], dot_value[194:131]
);

	cmd_t cmd;
	stat_t stat;
	logic [2:0] st;
	logic [63:0] vx, vy, vd;

	cva_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_mode(mode_t'(s_tdata[2:0])), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.stat(stat), .cmd(cmd)
	);

	cva_datapath #(.LANE_WIDTH(LANE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_mode(s_tdata[2:0]), .in_x(s_tdata[66:3]), .in_y(s_tdata[130:67]),
		.in_keep_x(s_tdata[131]), .in_keep_y(s_tdata[132]),
		.res_status(st), .res_x(vx), .res_y(vy), .res_dot(vd)
	);

	assign m_tdata = {5'd0, vd, vy, vx, st};

endmodule

>>> verif/tb_checked_vector_alu.sv
`timescale 1ns / 1ps

module tb_checked_vector_alu;
	import cva_pkg::*;

	typedef struct {
		status_t     status;
		logic [63:0] vx;
		logic [63:0] vy;
		logic [63:0] dot;
	} alu_result_t;

	// Tracks both lanes and holds the results that are still owed by the block
	class lane_scoreboard;
		logic [63:0] acc_x, acc_y;
		status_t     prev_status;
		alu_result_t owed[$];
		int          errors;
		int          checked;

		function new();
			acc_x = '0;
			acc_y = '0;
			prev_status = ST_OK;
			errors = 0;
			checked = 0;
		endfunction

		// Exact signed product, in range when it fits 64 bits
		function bit mul_fits(logic [63:0] a, logic [63:0] b, output logic [63:0] p);
			logic signed [127:0] full;
			full = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
			p = full[63:0];
			return full == {{64{full[63]}}, full[63:0]};
		endfunction

		function bit add_fits(logic [63:0] a, logic [63:0] b, output logic [63:0] s);
			logic [64:0] wide;
			wide = {a[63], a} + {b[63], b};
			s = wide[63:0];
			return wide[64] == wide[63];
		endfunction

		function bit sub_fits(logic [63:0] a, logic [63:0] b, output logic [63:0] s);
			logic [64:0] wide;
			wide = {a[63], a} - {b[63], b};
			s = wide[63:0];
			return wide[64] == wide[63];
		endfunction

		function bit div_legal(logic [63:0] a, logic [63:0] b);
			return !(b == 0 || (a == 64'h8000_0000_0000_0000 && b == '1));
		endfunction

		function logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
			logic [63:0] q;
			q = (a[63] ? -a : a) / (b[63] ? -b : b);
			return (a[63] ^ b[63]) ? -q : q;
		endfunction

		function void note_input(logic [2:0] op, logic [63:0] bx, logic [63:0] by,
				bit kx, bit ky);
			alu_result_t r;
			logic [63:0] rx, ry, s;
			bit okx, oky;
			r.status = ST_OK;
			r.dot = '0;
			case (mode_t'(op))
				MODE_LOAD: begin
					if (!kx) acc_x = bx;
					if (!ky) acc_y = by;
					prev_status = ST_OK;
				end
				MODE_ADD, MODE_SUB, MODE_MUL: begin
					if (op == MODE_ADD) begin
						okx = add_fits(acc_x, bx, rx);
						oky = add_fits(acc_y, by, ry);
					end else if (op == MODE_SUB) begin
						okx = sub_fits(acc_x, bx, rx);
						oky = sub_fits(acc_y, by, ry);
					end else begin
						okx = mul_fits(acc_x, bx, rx);
						oky = mul_fits(acc_y, by, ry);
					end
					if (okx && oky) begin
						acc_x = rx;
						acc_y = ry;
					end else begin
						r.status = (op == MODE_SUB) ? ST_UNDERFLOW : ST_OVERFLOW;
					end
					prev_status = r.status;
				end
				MODE_DIV: begin
					if (div_legal(acc_x, bx) && div_legal(acc_y, by)) begin
						acc_x = quotient(acc_x, bx);
						acc_y = quotient(acc_y, by);
					end else begin
						r.status = ST_DIV_ZERO;
					end
					prev_status = r.status;
				end
				MODE_NEG: begin
					if (acc_x == 64'h8000_0000_0000_0000 || acc_y == 64'h8000_0000_0000_0000)
						r.status = ST_UNDERFLOW;
					else begin
						acc_x = -acc_x;
						acc_y = -acc_y;
					end
					prev_status = r.status;
				end
				MODE_DOT: begin
					okx = mul_fits(acc_x, bx, rx);
					oky = mul_fits(acc_y, by, ry);
					if (okx && oky && add_fits(rx, ry, s)) r.dot = s;
					else r.status = ST_DOT_OVF;
				end
				default: ;
			endcase
			r.vx = acc_x;
			r.vy = acc_y;
			owed.push_back(r);
		endfunction

		function void check_result(logic [199:0] d);
			alu_result_t e;
			checked++;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (d[2:0] !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, d[2:0]);
				errors++;
			end
			if (d[66:3] !== e.vx) begin
				$display("%0t: vector_x expected %h actual %h", $time, e.vx, d[66:3]);
				errors++;
			end
			if (d[130:67] !== e.vy) begin
				$display("%0t: vector_y expected %h actual %h", $time, e.vy, d[130:67]);
				errors++;
			end
			if (d[194:131] !== e.dot) begin
				$display("%0t: dot_value expected %h actual %h", $time, e.dot, d[194:131]);
				errors++;
			end
			if (d[199:195] !== '0) begin
				$display("%0t: pad bits expected 0 actual %h", $time, d[199:195]);
				errors++;
			end
		endfunction
	endclass

	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG1 = '1;
	localparam int WATCHDOG = 20000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [199:0] m_tdata;

	lane_scoreboard sb = new();
	bit   quiet = 0;    // no idling in the closing part
	bit   hold_off = 0; // long receiver stall
	bit   timed_out = 0;
	int   sent = 0;
	int   idle_cycles = 0;
	int   mode_count[8];

	checked_vector_alu u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		if (arst_n && s_tvalid && s_tready) sb.note_input(s_tdata[2:0], s_tdata[66:3],
			s_tdata[130:67], s_tdata[131], s_tdata[132]);
	end

	// Receiver: random stall bursts, a long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
				m_tready <= 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 18);
				m_tready <= 0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(logic [2:0] op, logic [63:0] x, logic [63:0] y, bit kx, bit ky);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {3'b0, ky, kx, y, x, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mode_count[op]++;
		sent++;
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return MIN64;
			1: return MAX64;
			2: return NEG1;
			3: return 64'($urandom_range(0, 3));
			4: return 64'(signed'($urandom_range(0, 200)) - 100);
			5: return {$urandom, $urandom};
			6: return 64'(signed'({$urandom, $urandom}) >>> $urandom_range(0, 62));
			default: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
		endcase
	endfunction

	task automatic random_item();
		logic [2:0] op;
		op = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 9) < 2) op = MODE_LOAD;
		send_item(op, pick_value(), pick_value(), $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, each operation and each fault case
		send_item(MODE_DOT, 64'd5, 64'd7, 0, 0);
		send_item(MODE_LOAD, MAX64, MIN64, 0, 0);
		send_item(MODE_ADD, 64'd1, 64'd0, 0, 0);
		send_item(MODE_SUB, 64'd0, 64'd1, 0, 0);
		send_item(MODE_NEG, 64'd0, 64'd0, 0, 0);
		send_item(MODE_DIV, 64'd1, NEG1, 0, 0);
		send_item(MODE_DIV, 64'd0, 64'd3, 0, 0);
		send_item(MODE_MUL, 64'd2, 64'd1, 0, 0);
		send_item(MODE_LOAD, 64'd9, 64'd9, 1, 0);
		send_item(MODE_LOAD, 64'd0, -64'd7, 1, 1);
		send_item(MODE_DIV, 64'd2, 64'd2, 0, 0);
		send_item(MODE_LOAD, 64'h1_0000_0000, 64'd3, 0, 0);
		send_item(MODE_MUL, 64'h8000_0000, 64'd5, 0, 0);
		send_item(MODE_MUL, -64'h8000_0000, 64'd1, 0, 0);
		send_item(MODE_DOT, MAX64, 64'd1, 0, 0);
		send_item(MODE_LOAD, MIN64, 64'd1, 0, 0);
		send_item(MODE_DOT, NEG1, 64'd0, 0, 0);
		send_item(MODE_MUL, NEG1, 64'd1, 0, 0);
		send_item(MODE_LOAD, 64'd7, -64'd7, 0, 0);
		send_item(MODE_DIV, -64'd2, 64'd2, 0, 0);
		send_item(MODE_NEG, MAX64, MIN64, 1, 1);
		send_item(MODE_NOP, MAX64, MIN64, 1, 1);
		send_item(MODE_ADD, MAX64, MIN64, 0, 0);
		send_item(MODE_SUB, MIN64, MAX64, 0, 0);

		// Long receiver stall while items keep coming
		hold_off = 1;
		repeat (6) random_item();

		repeat (950) random_item();
		quiet = 1;
		repeat (150) random_item();
		s_tvalid <= 0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("Sent %0d items (load %0d add %0d sub %0d mul %0d div %0d neg %0d dot %0d nop %0d),",
			sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
			mode_count[4], mode_count[5], mode_count[6], mode_count[7]);
		$display("checked %0d results with %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
